// ----- hdl/strided_range_bit_toggle_unit_macros.svh -----
// ----------------------------------------------------------------------------
// strided_range_bit_toggle_unit_macros
// Assertion macros shared by the strided range bit toggle unit.
// ----------------------------------------------------------------------------
`ifndef STRIDED_RANGE_BIT_TOGGLE_UNIT_MACROS_SVH
`define STRIDED_RANGE_BIT_TOGGLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define SRBT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define SRBT_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRBT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRBT_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/srbt_pkg.sv -----
// ----------------------------------------------------------------------------
// srbt_pkg
// Types and constants of the strided range bit toggle unit.
// ----------------------------------------------------------------------------
package srbt_pkg;

    localparam int POS_W  = 11;
    localparam int IDX_W  = 4;
    localparam int WORD_W = 64;
    localparam int ACT_W  = 2;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_TOGGLE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_LENGTH_IN_USE = 1'b0;

    // Remainder operand select
    localparam logic DIV_PHASE = 1'b0;
    localparam logic DIV_STEP  = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [POS_W-1:0]  first_pos;
        logic [POS_W-1:0]  last_pos;
        logic [POS_W-1:0]  stride;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] load_data;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] read_word;
        logic [IDX_W-1:0]  read_index;
    } t_rsp;

    typedef struct packed {
        logic do_read;
        logic do_load;
        logic capture;
        logic div_start;
        logic div_sel;
        logic save_phase;
        logic save_step;
        logic sweep_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sweep_last;
        logic toggle_noop;
    } t_status;

endpackage

// ----- hdl/strided_range_bit_toggle_unit.sv -----
// ----------------------------------------------------------------------------
// strided_range_bit_toggle_unit
// Read and load requests complete in the accept cycle; the read result
// strobes in the cycle after. A toggle request that is not a no-op holds busy
// through two passes of the bit-serial remainder unit, then a sweep of
// W = min(ceil(BITS/64), 32) words, one word per cycle.
// Reset (synchronous, active low) clears the bitmap and sets the length to 1024.
// ----------------------------------------------------------------------------
//
// Bitmap of BITS positions kept as 64-bit words in flip-flops. A toggle
// request inverts first, first+stride, ... up to min(last, length). The sweep
// builds each word's mask from three pieces:
//   - a stride pattern (bits at multiples of stride), doubled up after capture,
//   - the pattern phase for the word, backed off by 64 mod stride per word,
//   - a window that keeps only positions between first and the clipped top.
// The starting phase is (first-1) mod stride; both remainders come from one
// shared remainder unit. The receiver cannot stall: a result appears on o_rsp
// with o_rsp_valid, held to the next read. Write length_in_use only while idle.
//
module strided_range_bit_toggle_unit
    import srbt_pkg::*;
#(
    parameter int BITS = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    // result channel
    output logic              o_rsp_valid,
    output t_rsp              o_rsp,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [POS_W-1:0] r_length;
    logic             cfg_wr;
    t_cmd             cmd;
    t_status          status;
    logic             ctrl_busy;

    // Configuration register: byte address 0, bit 2 of paddr selects it
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LENGTH_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= LEN_RESET;
        end else if (cfg_wr) begin
            r_length <= pwdata[POS_W-1:0];
        end
    end

    // Answer a read with the length; other addresses read as zero
    assign prdata = (paddr[2] == REG_LENGTH_IN_USE) ? DATA_W'(r_length) : '0;
    assign pready = 1'b1;

    // Sequence the requests
    srbt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    // Hold the bitmap, build masks, drive the result register
    srbt_datapath #(
        .BITS (BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_length    (r_length),
        .o_status    (status),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

    assign busy = ctrl_busy;

endmodule

// ----- hdl/srbt_rem_unit.sv -----
// ----------------------------------------------------------------------------
// srbt_rem_unit
// Iterative restoring remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srbt_rem_unit
    import srbt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [POS_W-1:0] i_dividend,
    input  logic [POS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [POS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(POS_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [POS_W-1:0] r_rem;
    logic [POS_W-1:0] r_dvd;
    logic [POS_W-1:0] r_dvs;
    logic [POS_W:0]   rem_sh;
    logic [POS_W:0]   rem_sub;
    logic [POS_W-1:0] n_rem;

    always_comb begin
        rem_sh  = {r_rem, r_dvd[POS_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        if (rem_sh >= {1'b0, r_dvs}) begin
            n_rem = rem_sub[POS_W-1:0];
        end else begin
            n_rem = rem_sh[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(POS_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[POS_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hdl/srbt_datapath.sv -----
// ----------------------------------------------------------------------------
// srbt_datapath
// Bitmap words, stride pattern builder, word sweep and read masking.
// ----------------------------------------------------------------------------
`include "strided_range_bit_toggle_unit_macros.svh"

module srbt_datapath
    import srbt_pkg::*;
#(
    parameter int BITS = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_req             i_req,
    input  logic [POS_W-1:0] i_length,
    output t_status          o_status,
    output t_rsp             o_rsp,
    output logic             o_rsp_valid
);

    localparam int WORDS   = (BITS + 63) / 64;
    // positions never pass 2047, so no word past the 32nd is ever touched
    localparam int NW      = (WORDS < 32) ? WORDS : 32;
    localparam int IW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int LEN_CAP = (BITS < 2047) ? BITS : 2047;

    logic [WORD_W-1:0]       r_bitmap [NW];
    logic                    r_rsp_valid;
    t_rsp                    r_rsp;
    logic [POS_W-1:0]        r_lo;
    logic signed [POS_W:0]   r_hi;
    logic [POS_W-1:0]        r_s;
    logic [WORD_W-1:0]       r_q;
    logic [6:0]              r_qsh;
    logic [POS_W-1:0]        r_ph;
    logic [POS_W-1:0]        r_m;
    logic [IW-1:0]           r_w;

    logic [POS_W-1:0]        len_eff;
    logic [POS_W-1:0]        top;
    logic                    rd_ok;
    logic [IW-1:0]           rd_addr;
    logic [IW-1:0]           acc_addr;
    logic [WORD_W-1:0]       cur;
    logic [POS_W:0]          rd_base;
    logic [POS_W:0]          rd_diff;
    logic [WORD_W-1:0]       vmask;
    logic [POS_W+1:0]        w_base;
    logic signed [POS_W+1:0] lo_off;
    logic signed [POS_W+1:0] hi_off;
    logic [WORD_W-1:0]       ge_mask;
    logic [WORD_W-1:0]       le_mask;
    logic [WORD_W-1:0]       st_mask;
    logic [POS_W:0]          ph_wrap;
    logic [POS_W-1:0]        n_ph;
    logic [POS_W-1:0]        dividend;
    logic                    rem_done;
    logic [POS_W-1:0]        rem;
    logic                    wr_en;
    logic [WORD_W-1:0]       wr_data;

    srbt_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_s),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    assign dividend = (i_cmd.div_sel == DIV_STEP) ? POS_W'(64) : r_lo;

    // Clip the length and the top of the toggle range
    always_comb begin
        len_eff = (i_length < POS_W'(LEN_CAP)) ? i_length : POS_W'(LEN_CAP);
        top     = (i_req.last_pos < len_eff) ? i_req.last_pos : len_eff;
    end

    // One shared word port: sweep word while sweeping, request word otherwise
    always_comb begin
        rd_ok    = (32'(i_req.word_index) < WORDS);
        rd_addr  = IW'(i_req.word_index);
        acc_addr = i_cmd.sweep_step ? r_w : rd_addr;
        cur      = r_bitmap[acc_addr];
    end

    // Read mask: drop bits past the length
    always_comb begin
        rd_base = {2'b00, i_req.word_index, 6'b000000};
        rd_diff = {1'b0, len_eff} - rd_base;
        if ({1'b0, len_eff} <= rd_base) begin
            vmask = '0;
        end else if (rd_diff >= (POS_W+1)'(64)) begin
            vmask = '1;
        end else begin
            vmask = ~({WORD_W{1'b1}} << rd_diff[5:0]);
        end
    end

    // Sweep mask for the current word: range window and stride pattern
    always_comb begin
        w_base = (POS_W+2)'({r_w, 6'b000000});
        lo_off = $signed({2'b00, r_lo}) - $signed(w_base);
        hi_off = $signed({r_hi[POS_W], r_hi}) - $signed(w_base);
        if (lo_off <= 0) begin
            ge_mask = '1;
        end else if (lo_off >= 64) begin
            ge_mask = '0;
        end else begin
            ge_mask = {WORD_W{1'b1}} << lo_off[5:0];
        end
        if (hi_off < 0) begin
            le_mask = '0;
        end else if (hi_off >= 63) begin
            le_mask = '1;
        end else begin
            le_mask = {WORD_W{1'b1}} >> (6'd63 - hi_off[5:0]);
        end
        if (r_ph >= POS_W'(64)) begin
            st_mask = '0;
        end else begin
            st_mask = r_q << r_ph[5:0];
        end
        // phase of the next word: back off by 64 mod stride, wrap once
        ph_wrap = {1'b0, r_ph} + {1'b0, r_s} - {1'b0, r_m};
        if (r_ph >= r_m) begin
            n_ph = r_ph - r_m;
        end else begin
            n_ph = ph_wrap[POS_W-1:0];
        end
    end

    always_comb begin
        wr_en   = (i_cmd.do_load && rd_ok) || i_cmd.sweep_step;
        wr_data = i_cmd.sweep_step ? (cur ^ (ge_mask & le_mask & st_mask))
                                   : i_req.load_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            for (int k = 0; k < NW; k++) begin
                r_bitmap[k] <= '0;
            end
        end else begin
            r_rsp_valid <= i_cmd.do_read;
            if (wr_en) begin
                r_bitmap[acc_addr] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_read) begin
            r_rsp.read_word  <= rd_ok ? (cur & vmask) : '0;
            r_rsp.read_index <= i_req.word_index;
        end
        if (i_cmd.capture) begin
            r_lo  <= i_req.first_pos - 1'b1;
            r_hi  <= $signed({1'b0, top}) - 12'sd1;
            r_s   <= i_req.stride;
            r_q   <= WORD_W'(1);
            r_qsh <= (i_req.stride >= POS_W'(64)) ? 7'd64 : i_req.stride[6:0];
        end else begin
            // double the pattern; once saturated it holds
            r_q   <= r_q | (r_q << r_qsh);
            r_qsh <= (r_qsh >= 7'd32) ? 7'd64 : {r_qsh[5:0], 1'b0};
        end
        if (i_cmd.save_phase) begin
            r_ph <= rem;
        end else if (i_cmd.sweep_step) begin
            r_ph <= n_ph;
        end
        if (i_cmd.save_step) begin
            r_m <= rem;
            r_w <= '0;
        end else if (i_cmd.sweep_step) begin
            r_w <= r_w + 1'b1;
        end
    end

    always_comb begin
        o_status.div_done    = rem_done;
        o_status.sweep_last  = (r_w == IW'(NW - 1));
        o_status.toggle_noop = (i_req.stride == '0) || (i_req.first_pos == '0) ||
                               (i_req.first_pos > i_req.last_pos);
    end

    assign o_rsp       = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

    `SRBT_ASSERT(a_rsp_after_read, i_clk, i_rst_n,
        r_rsp_valid |-> $past(i_cmd.do_read), "result strobe without a read request")
    `SRBT_ASSERT(a_phase_in_range, i_clk, i_rst_n,
        i_cmd.sweep_step |-> ((r_ph < r_s) && (r_m < r_s)), "sweep phase not below stride")
    `SRBT_ASSERT(a_sweep_alone, i_clk, i_rst_n,
        i_cmd.sweep_step |-> !(i_cmd.do_read || i_cmd.do_load || i_cmd.capture),
        "request command during a sweep")

endmodule

// ----- hdl/srbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// srbt_ctrl
// Request decode and toggle sequencing: two remainders, then a word sweep.
// ----------------------------------------------------------------------------
`include "strided_range_bit_toggle_unit_macros.svh"

module srbt_ctrl
    import srbt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACT_W-1:0] i_action,
    input  t_status          i_status,
    output t_cmd             o_cmd,
    output logic             o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_A,
        ST_WAIT_A,
        ST_START_B,
        ST_WAIT_B,
        ST_SWEEP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        ACT_READ: begin
                            o_cmd.do_read = 1'b1;
                        end
                        ACT_LOAD: begin
                            o_cmd.do_load = 1'b1;
                        end
                        ACT_TOGGLE: begin
                            o_cmd.capture = 1'b1;
                            if (!i_status.toggle_noop) begin
                                n_state = ST_START_A;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_START_A: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PHASE;
                n_state         = ST_WAIT_A;
            end
            ST_WAIT_A: begin
                if (i_status.div_done) begin
                    o_cmd.save_phase = 1'b1;
                    n_state          = ST_START_B;
                end
            end
            ST_START_B: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STEP;
                n_state         = ST_WAIT_B;
            end
            ST_WAIT_B: begin
                if (i_status.div_done) begin
                    o_cmd.save_step = 1'b1;
                    n_state         = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `SRBT_ASSERT(a_toggle_starts, i_clk, i_rst_n, (o_cmd.capture && !i_status.toggle_noop) |=> (r_state == ST_START_A), "toggle request did not start the sequence")
    `SRBT_ASSERT(a_done_when_waiting, i_clk, i_rst_n, i_status.div_done |-> ((r_state == ST_WAIT_A) || (r_state == ST_WAIT_B)), "remainder done outside a wait state")
    `SRBT_ASSERT_NORST(a_reset_idle, i_clk, !i_rst_n |=> (r_state == ST_IDLE), "controller not idle after reset")

endmodule
